// File: rtl/core/hcpid_pkg.sv
package hcpid_pkg;

   // Gain fixed point and integral width
   localparam int GAIN_FRAC_BITS = 8;
   localparam int SUM_WIDTH      = 32;

   localparam int TEMP_W  = 16;
   localparam int GAIN_W  = 20;
   localparam int DUTY_W  = 16;
   localparam int ERR_W   = TEMP_W + 1;
   localparam int DERIV_W = ERR_W + 1;

   // Signed P/D products of a zero-extended gain; I is unsigned
   localparam int P_W    = GAIN_W + 1 + ERR_W;
   localparam int D_W    = GAIN_W + 1 + DERIV_W;
   localparam int IMAG_W = GAIN_W + SUM_WIDTH;

   // Integral term saturates at magnitude 2**TERM_LIMIT_LOG2
   localparam int TERM_LIMIT_LOG2 = 60;
   localparam int TERM_W          = TERM_LIMIT_LOG2 + 1;
   localparam int IEXT_W          = (IMAG_W > TERM_W) ? IMAG_W : TERM_W;
   localparam int TOTAL_W         = TERM_W + 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = GAIN_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT,
      CSR_DEADBAND,
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_PWM_FS
   } csr_index_type;

   typedef struct packed {
      logic [ERR_W-1:0]     err;
      logic [DERIV_W-1:0]   deriv;
      logic [SUM_WIDTH-1:0] esum;
      logic                 hold;
   } err_stage_type;

   typedef struct packed {
      logic [P_W-1:0]    p_term;
      logic [D_W-1:0]    d_term;
      logic [IMAG_W-1:0] i_mag;
      logic              i_neg;
      logic              hold;
   } mult_stage_type;

endpackage

// File: rtl/core/heat_cool_pid_controller_top.sv
// Heat/cool PID temperature controller with deadband.
// Request channel (req_valid/req_ready/req_temp_sample): one temperature
// sample per request, in hundredths of a degree. Response channel
// (rsp_valid/rsp_ready/rsp_*): exactly one response per request, in order,
// carrying the heat duty, the cool duty and the holding flag.
// Configuration port (csr_wr_en/csr_index/csr_wdata): write-only registers
// setpoint, deadband, three Q12.8 gains and PWM full scale; unused indexes
// are dropped. Write them only while no request is in flight.
// Throughput: one request per cycle while rsp_ready is high. The response
// passes the sample register, error/integral stage, multiplier stage and
// duty/output register. The integral and the previous error are updated as
// a request enters the error stage, so back-to-back samples chain through
// them without a gap.
// Reset: configuration returns to its defaults, the integral, previous error
// and held duties clear, and the pipeline empties.
// Receiver stall: the response register holds; each stage keeps advancing
// into empty slots ahead of it, so requests are still taken until every
// stage is full.
module heat_cool_pid_controller_top import hcpid_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TEMP_W-1:0]     req_temp_sample,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DUTY_W-1:0]     rsp_heat_duty,
   output logic [DUTY_W-1:0]     rsp_cool_duty,
   output logic                  rsp_holding,

   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [TEMP_W-1:0] setpoint_ff;
   logic [TEMP_W-1:0] deadband_ff;
   logic [GAIN_W-1:0] gain_p_ff;
   logic [GAIN_W-1:0] gain_i_ff;
   logic [GAIN_W-1:0] gain_d_ff;
   logic [DUTY_W-1:0] full_scale_ff;

   // Pipeline occupancy
   logic              sample_valid_ff;
   logic              err_valid_ff;
   logic              mult_valid_ff;
   logic              rsp_valid_ff;
   logic [TEMP_W-1:0] sample_ff;

   logic              ready_rsp;
   logic              ready_mult;
   logic              ready_err;
   logic              ready_sample;

   err_stage_type     err_stage;
   mult_stage_type    mult_stage;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= TEMP_W'(2500);
         deadband_ff   <= TEMP_W'(40);
         gain_p_ff     <= GAIN_W'(64000);
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         full_scale_ff <= DUTY_W'(1000);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SETPOINT: setpoint_ff   <= csr_wdata[TEMP_W-1:0];
            CSR_DEADBAND: deadband_ff   <= csr_wdata[TEMP_W-1:0];
            CSR_GAIN_P:   gain_p_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:   gain_i_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:   gain_d_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_PWM_FS:   full_scale_ff <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or its contents move on this cycle
   always_comb begin
      ready_rsp    = !rsp_valid_ff || rsp_ready;
      ready_mult   = !mult_valid_ff || ready_rsp;
      ready_err    = !err_valid_ff || ready_mult;
      ready_sample = !sample_valid_ff || ready_err;
   end

   assign req_ready = ready_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
         err_valid_ff    <= 1'b0;
         mult_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (ready_sample) begin
            sample_valid_ff <= req_valid;
         end
         if (ready_err) begin
            err_valid_ff <= sample_valid_ff;
         end
         if (ready_mult) begin
            mult_valid_ff <= err_valid_ff;
         end
         if (ready_rsp) begin
            rsp_valid_ff <= mult_valid_ff;
         end
      end
   end

   // Capture the sample of an accepted request
   always_ff @(posedge clock) begin
      if (req_valid && ready_sample) begin
         sample_ff <= req_temp_sample;
      end
   end

   hcpid_err_stage u_err_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (sample_valid_ff && ready_err),
      .sample   (sample_ff),
      .setpoint (setpoint_ff),
      .deadband (deadband_ff),
      .stage_ff (err_stage)
   );

   hcpid_mult_stage u_mult_stage (
      .clock    (clock),
      .load     (err_valid_ff && ready_mult),
      .stage    (err_stage),
      .gain_p   (gain_p_ff),
      .gain_i   (gain_i_ff),
      .gain_d   (gain_d_ff),
      .stage_ff (mult_stage)
   );

   hcpid_duty_stage u_duty_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (mult_valid_ff && ready_rsp),
      .stage      (mult_stage),
      .full_scale (full_scale_ff),
      .heat_duty  (rsp_heat_duty),
      .cool_duty  (rsp_cool_duty),
      .holding    (rsp_holding)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/hcpid_err_stage.sv
module hcpid_err_stage import hcpid_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [TEMP_W-1:0]   sample,
   input  logic [TEMP_W-1:0]   setpoint,
   input  logic [TEMP_W-1:0]   deadband,
   output err_stage_type       stage_ff
);

   logic [SUM_WIDTH-1:0] error_sum_ff;
   logic [SUM_WIDTH-1:0] error_sum_in;
   logic [ERR_W-1:0]     last_error_ff;
   logic [ERR_W-1:0]     last_error_in;
   err_stage_type        stage_in;

   logic [ERR_W-1:0]     err;
   logic [ERR_W-1:0]     err_mag;
   logic [SUM_WIDTH:0]   sum_wide;
   logic [SUM_WIDTH-1:0] sum_sat;
   logic                 hold;

   always_comb begin
      err      = {1'b0, setpoint} - {1'b0, sample};
      err_mag  = err[ERR_W-1] ? (~err + 1'b1) : err;
      hold     = (err_mag <= {1'b0, deadband});
      sum_wide = {error_sum_ff[SUM_WIDTH-1], error_sum_ff}
               + {{(SUM_WIDTH + 1 - ERR_W){err[ERR_W-1]}}, err};
      // Clamp to the signed range on overflow
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
      error_sum_in   = hold ? '0 : sum_sat;
      last_error_in  = hold ? '0 : err;
      stage_in.err   = err;
      stage_in.deriv = {err[ERR_W-1], err} - {last_error_ff[ERR_W-1], last_error_ff};
      stage_in.esum  = sum_sat;
      stage_in.hold  = hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (load) begin
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: rtl/core/hcpid_mult_stage.sv
module hcpid_mult_stage import hcpid_pkg::*; (
   input  logic                clock,
   input  logic                load,
   input  err_stage_type       stage,
   input  logic [GAIN_W-1:0]   gain_p,
   input  logic [GAIN_W-1:0]   gain_i,
   input  logic [GAIN_W-1:0]   gain_d,
   output mult_stage_type      stage_ff
);

   mult_stage_type       stage_in;
   logic [SUM_WIDTH-1:0] esum_mag;

   always_comb begin
      esum_mag = stage.esum[SUM_WIDTH-1] ? (~stage.esum + 1'b1) : stage.esum;
      stage_in.p_term = $signed({1'b0, gain_p}) * $signed(stage.err);
      stage_in.d_term = $signed({1'b0, gain_d}) * $signed(stage.deriv);
      stage_in.i_mag  = IMAG_W'(gain_i) * IMAG_W'(esum_mag);
      stage_in.i_neg  = stage.esum[SUM_WIDTH-1];
      stage_in.hold   = stage.hold;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: rtl/core/hcpid_duty_stage.sv
module hcpid_duty_stage import hcpid_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mult_stage_type      stage,
   input  logic [DUTY_W-1:0]   full_scale,
   output logic [DUTY_W-1:0]   heat_duty,
   output logic [DUTY_W-1:0]   cool_duty,
   output logic                holding
);

   logic [DUTY_W-1:0]  heat_level_ff;
   logic [DUTY_W-1:0]  heat_level_in;
   logic [DUTY_W-1:0]  cool_level_ff;
   logic [DUTY_W-1:0]  cool_level_in;
   logic               holding_ff;
   logic               holding_in;

   logic [IEXT_W-1:0]  i_ext;
   logic [IEXT_W-1:0]  i_limit;
   logic [IEXT_W-1:0]  i_sat;
   logic [TOTAL_W-1:0] i_term;
   logic [TOTAL_W-1:0] pid_sum;
   logic [TOTAL_W-1:0] sum_mag;
   logic [TOTAL_W-1:0] shifted;
   logic [DUTY_W-1:0]  duty;
   logic               positive;

   always_comb begin
      i_ext   = IEXT_W'(stage.i_mag);
      i_limit = IEXT_W'(1) << TERM_LIMIT_LOG2;
      i_sat   = (i_ext > i_limit) ? i_limit : i_ext;
      i_term  = {{(TOTAL_W - TERM_W){1'b0}}, i_sat[TERM_W-1:0]};
      if (stage.i_neg) begin
         i_term = ~i_term + 1'b1;
      end
      pid_sum = {{(TOTAL_W - P_W){stage.p_term[P_W-1]}}, stage.p_term}
              + {{(TOTAL_W - D_W){stage.d_term[D_W-1]}}, stage.d_term}
              + i_term;
      positive = !pid_sum[TOTAL_W-1] && (|pid_sum);
      sum_mag  = pid_sum[TOTAL_W-1] ? (~pid_sum + 1'b1) : pid_sum;
      shifted  = sum_mag >> GAIN_FRAC_BITS;
      duty     = (shifted > TOTAL_W'(full_scale)) ? full_scale : shifted[DUTY_W-1:0];

      heat_level_in = heat_level_ff;
      cool_level_in = cool_level_ff;
      holding_in    = stage.hold;
      if (stage.hold) begin
         heat_level_in = heat_level_ff;
      end else if (positive) begin
         heat_level_in = duty;
         cool_level_in = '0;
      end else begin
         heat_level_in = '0;
         cool_level_in = duty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_level_ff <= '0;
         cool_level_ff <= '0;
         holding_ff    <= 1'b0;
      end else if (load) begin
         heat_level_ff <= heat_level_in;
         cool_level_ff <= cool_level_in;
         holding_ff    <= holding_in;
      end
   end

   assign heat_duty = heat_level_ff;
   assign cool_duty = cool_level_ff;
   assign holding   = holding_ff;

endmodule
